// ===== hw/rtl/sqs_pkg.sv =====
// ----------------------------------------------------------------------------
// sqs_pkg
// Shared constants, status codes, controller states and command/status types
// for the symmetric quartic solver.
// ----------------------------------------------------------------------------
`default_nettype none

package sqs_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int SQRT_STEPS_DEF = 48;

    // Fixed widths from the coefficient and root formats.
    localparam int COEF_W = 32;
    localparam int ROOT_W = 32;
    // Wide working width: discriminants reach about 2^100.
    localparam int WIDE_W = 128;
    // Square root and z magnitudes.
    localparam int HALF_W = 64;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOT_SYM = 2'd1,
        ST_NO_ROOT = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISC,     // start D1 products
        S_DISC_W,   // wait for D1 products
        S_DISC_F,   // form D1
        S_SQ1,      // start sqrt of D1
        S_SQ1_W,
        S_DIV1,     // start z1 division
        S_DIV1_W,
        S_DIV2,     // start z2 division
        S_DIV2_W,
        S_IN_SEL,   // select z for inner equation
        S_IN_MUL,   // start z*z
        S_IN_MUL_W,
        S_IN_SQ,    // start sqrt of D2
        S_IN_SQ_W,
        S_IN_FIN,   // form two roots
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DISC,
        CMD_DISC_F,
        CMD_SQ1,
        CMD_DIV1,
        CMD_DIV2,
        CMD_IN_SEL
    } t_cmd_op;

    typedef enum logic [1:0] {
        CMD2_NONE,
        CMD2_IN_MUL,
        CMD2_IN_SQ,
        CMD2_IN_FIN
    } t_cmd_in;

    typedef struct packed {
        t_cmd_op op;
        t_cmd_in inner;
        logic    second;   // inner equation works on the second z
    } t_cmd;

    typedef struct packed {
        logic a_zero;
        logic d1_neg;
        logic d1_zero;
        logic d2_neg;
        logic mul_done;
        logic sqrt_done;
        logic div_done;
    } t_stat;

    // Bit length of a wide value.
    function automatic logic [7:0] bitlen(input logic [WIDE_W-1:0] v);
        logic [7:0] n;
        n = 8'd0;
        for (int i = 0; i < WIDE_W; i++) begin
            if (v[i]) begin
                n = 8'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sqs_mul.sv =====
// ----------------------------------------------------------------------------
// sqs_mul
// Unsigned 64x64 multiplier built from one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_mul (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire [sqs_pkg::HALF_W-1:0] i_x,
    input  wire [sqs_pkg::HALF_W-1:0] i_y,
    output logic                      o_done,
    output logic [sqs_pkg::WIDE_W-1:0] o_p
);
    import sqs_pkg::*;

    logic [HALF_W-1:0] r_x, r_y;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic [WIDE_W-1:0] r_acc, n_acc;
    logic [31:0]       w_xs, w_ys;
    logic [63:0]       w_pp;
    logic [6:0]        w_sh;

    // Select the partial product of this cycle.
    always_comb begin
        w_xs = r_cnt[0] ? r_x[63:32] : r_x[31:0];
        w_ys = r_cnt[1] ? r_y[63:32] : r_y[31:0];
        w_pp = 64'(w_xs) * 64'(w_ys);
        w_sh = {(2'(r_cnt[0]) + 2'(r_cnt[1])), 5'd0};
    end

    // Advance the sequence over the four partial products.
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 3'd0;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = r_acc + (WIDE_W'(w_pp) << w_sh);
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd3) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_done = r_busy && (r_cnt == 3'd4 - 3'd1) ? 1'b0 : (!r_busy && r_cnt == 3'd4);
    assign o_p    = r_acc;

endmodule

`default_nettype wire

// ===== hw/rtl/sqs_sqrt.sv =====
// ----------------------------------------------------------------------------
// sqs_sqrt
// Bisection square root, bounded by a step count; starts only from idle.
// Each step squares mid on its own partial-product multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_sqrt #(
    parameter int SQRT_STEPS = sqs_pkg::SQRT_STEPS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire [sqs_pkg::WIDE_W-1:0]  i_d,
    output logic                       o_done,
    output logic [sqs_pkg::HALF_W-1:0] o_root
);
    import sqs_pkg::*;

    localparam int STEP_W = $clog2(SQRT_STEPS + 1);

    typedef enum logic [1:0] {SQ_IDLE, SQ_TEST, SQ_MUL, SQ_DONE} t_sq_state;

    t_sq_state         r_st, n_st;
    logic [WIDE_W-1:0] r_d;
    logic [HALF_W:0]   r_lo, r_hi, n_lo, n_hi;
    logic [STEP_W-1:0] r_step, n_step;
    logic [HALF_W-1:0] w_mid;
    logic [7:0]        w_n;
    logic [7:0]        w_hsh;
    logic              w_mstart, w_mdone;
    logic [WIDE_W-1:0] w_msq;
    logic [HALF_W:0]   w_gap;

    assign w_n   = bitlen(i_d);
    assign w_hsh = (w_n + 8'd1) >> 1;
    assign w_gap = r_hi - r_lo;
    assign w_mid = HALF_W'(r_lo + (w_gap >> 1));

    sqs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_x     (w_mid),
        .i_y     (w_mid),
        .o_done  (w_mdone),
        .o_p     (w_msq)
    );

    // Sequence the bisection steps.
    always_comb begin
        n_st     = r_st;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_step   = r_step;
        w_mstart = 1'b0;
        unique case (r_st)
            SQ_IDLE: begin
                if (i_start) begin
                    n_lo   = '0;
                    n_hi   = (w_n == 8'd0) ? '0 : ((HALF_W+1)'(1) << w_hsh);
                    n_step = '0;
                    n_st   = SQ_TEST;
                end
            end
            SQ_TEST: begin
                if (w_gap <= (HALF_W+1)'(1) || r_step == STEP_W'(SQRT_STEPS)) begin
                    n_st = SQ_DONE;
                end else begin
                    w_mstart = 1'b1;
                    n_st     = SQ_MUL;
                end
            end
            SQ_MUL: begin
                if (w_mdone) begin
                    if (w_msq <= r_d) begin
                        n_lo = {1'b0, w_mid};
                    end else begin
                        n_hi = {1'b0, w_mid};
                    end
                    n_step = r_step + STEP_W'(1);
                    n_st   = SQ_TEST;
                end
            end
            SQ_DONE: begin
                n_st = SQ_IDLE;
            end
            default: n_st = SQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SQ_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_step <= n_step;
        if (i_start && r_st == SQ_IDLE) begin
            r_d <= i_d;
        end
    end

    assign o_done = (r_st == SQ_DONE);
    assign o_root = r_lo[HALF_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/sqs_div.sv =====
// ----------------------------------------------------------------------------
// sqs_div
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire                        i_num_neg,
    input  wire [sqs_pkg::HALF_W-1:0]  i_num_mag,
    input  wire signed [sqs_pkg::HALF_W-1:0] i_den,
    output logic                       o_done,
    output logic signed [sqs_pkg::HALF_W-1:0] o_quot
);
    import sqs_pkg::*;

    localparam int CNT_W = $clog2(HALF_W + 1);

    logic              r_busy, r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [HALF_W-1:0] r_num, r_quo, r_den;
    logic [HALF_W:0]   r_rem;
    logic              r_neg;
    logic [HALF_W:0]   w_trial;
    logic [HALF_W:0]   w_sub;
    logic              w_go;

    // Take a start only while idle; the request may stay high over the run.
    assign w_go    = i_start && !r_busy && !r_done;
    assign w_trial = {r_rem[HALF_W-1:0], r_num[HALF_W-1]};
    assign w_sub   = w_trial - {1'b0, r_den};

    // Shift one numerator bit in and subtract where it fits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (w_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(HALF_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (w_go) begin
            r_num <= i_num_mag;
            r_den <= i_den[HALF_W-1] ? HALF_W'(-i_den) : HALF_W'(i_den);
            r_neg <= i_num_neg ^ i_den[HALF_W-1];
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[HALF_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
            if (!w_sub[HALF_W]) begin
                r_rem <= w_sub;
                r_quo <= {r_quo[HALF_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[HALF_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

// ===== hw/rtl/sqs_datapath.sv =====
// ----------------------------------------------------------------------------
// sqs_datapath
// Operand registers, discriminants, square root, divider and root assembly.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_datapath #(
    parameter int FRAC_BITS  = sqs_pkg::FRAC_BITS_DEF,
    parameter int SQRT_STEPS = sqs_pkg::SQRT_STEPS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire sqs_pkg::t_cmd                i_cmd,
    input  wire signed [sqs_pkg::COEF_W-1:0]  i_coef_a,
    input  wire signed [sqs_pkg::COEF_W-1:0]  i_coef_b,
    input  wire signed [sqs_pkg::COEF_W-1:0]  i_coef_c,
    output sqs_pkg::t_stat                    o_stat,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_0,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_1,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_2,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_3
);
    import sqs_pkg::*;

    localparam logic [WIDE_W-1:0] FOUR = WIDE_W'(1) << (2 * FRAC_BITS + 2);
    localparam logic signed [HALF_W-1:0] RMAX = HALF_W'(64'sh7FFF_FFFF);
    localparam logic signed [HALF_W-1:0] RMIN = -HALF_W'(64'sh8000_0000);

    logic signed [COEF_W-1:0] r_a, r_b, r_c;
    logic signed [HALF_W-1:0] w_t;
    logic              r_pneg;
    logic [WIDE_W-1:0] r_d1;
    logic              r_d1_neg;
    logic [HALF_W-1:0] r_s1;
    logic signed [HALF_W-1:0] r_z1, r_z2, r_z;
    logic [WIDE_W-1:0] r_zz;
    logic [HALF_W-1:0] r_s2;

    // Shared multiplier: b*b then a*t, then z*z.
    logic              w_mstart, w_mdone;
    logic [HALF_W-1:0] w_mx, w_my;
    logic [WIDE_W-1:0] w_mp;
    logic [WIDE_W-1:0] r_bb;
    logic [1:0]        r_mphase;

    logic              w_sstart, w_sdone;
    logic [WIDE_W-1:0] w_sd;
    logic [HALF_W-1:0] w_sroot;

    logic              w_dstart, w_ddone, w_dneg;
    logic [HALF_W-1:0] w_dmag;
    logic signed [HALF_W-1:0] w_dq;
    logic signed [HALF_W-1:0] w_nb;
    logic signed [HALF_W-1:0] w_num;
    logic [WIDE_W-1:0] w_p4;
    logic signed [HALF_W-1:0] w_xp, w_xm;

    function automatic logic [HALF_W-1:0] mag64(input logic signed [HALF_W-1:0] v);
        return v[HALF_W-1] ? HALF_W'(-v) : HALF_W'(v);
    endfunction

    function automatic logic signed [ROOT_W-1:0] sat(input logic signed [HALF_W-1:0] v);
        logic signed [ROOT_W-1:0] r;
        if (v > RMAX) begin
            r = ROOT_W'(RMAX);
        end else if (v < RMIN) begin
            r = ROOT_W'(RMIN);
        end else begin
            r = ROOT_W'(v);
        end
        return r;
    endfunction

    assign w_t = HALF_W'(r_c) - (HALF_W'(r_a) <<< 1);

    sqs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_x     (w_mx),
        .i_y     (w_my),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    sqs_sqrt #(.SQRT_STEPS(SQRT_STEPS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sstart),
        .i_d     (w_sd),
        .o_done  (w_sdone),
        .o_root  (w_sroot)
    );

    sqs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_dstart),
        .i_num_neg (w_dneg),
        .i_num_mag (w_dmag),
        .i_den     (HALF_W'(r_a) <<< 1),
        .o_done    (w_ddone),
        .o_quot    (w_dq)
    );

    // Route operands to the shared units.
    always_comb begin
        w_mstart = 1'b0;
        w_mx     = mag64(HALF_W'(r_b));
        w_my     = mag64(HALF_W'(r_b));
        if (i_cmd.op == CMD_DISC) begin
            w_mstart = 1'b1;
        end else if (r_mphase == 2'd1 && w_mdone) begin
            w_mstart = 1'b1;
            w_mx     = mag64(HALF_W'(r_a));
            w_my     = mag64(w_t);
        end else if (i_cmd.inner == CMD2_IN_MUL) begin
            w_mstart = 1'b1;
            w_mx     = mag64(r_z);
            w_my     = mag64(r_z);
        end
        w_sstart = (i_cmd.op == CMD_SQ1) || (i_cmd.inner == CMD2_IN_SQ);
        w_sd     = (i_cmd.op == CMD_SQ1) ? r_d1 : r_zz - FOUR;
        w_nb     = -HALF_W'(r_b);
        w_num    = (i_cmd.op == CMD_DIV1) ? w_nb + $signed({1'b0, r_s1[HALF_W-2:0]})
                                          : w_nb - $signed({1'b0, r_s1[HALF_W-2:0]});
        w_dstart = (i_cmd.op == CMD_DIV1) || (i_cmd.op == CMD_DIV2);
        w_dneg   = w_num[HALF_W-1];
        w_dmag   = mag64(w_num) << FRAC_BITS;
        w_p4     = w_mp << 2;
        w_xp     = (r_z + $signed({1'b0, r_s2[HALF_W-2:0]})) / 2;
        w_xm     = (r_z - $signed({1'b0, r_s2[HALF_W-2:0]})) / 2;
    end

    // Hold operands and intermediate values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mphase <= 2'd0;
        end else if (i_cmd.op == CMD_DISC) begin
            r_mphase <= 2'd1;
        end else if (r_mphase == 2'd1 && w_mdone) begin
            r_mphase <= 2'd2;
        end else if (r_mphase == 2'd2 && w_mdone) begin
            r_mphase <= 2'd3;
        end else if (i_cmd.op == CMD_DISC_F) begin
            r_mphase <= 2'd0;
        end
        if (i_cmd.op == CMD_LOAD) begin
            r_a <= i_coef_a;
            r_b <= i_coef_b;
            r_c <= i_coef_c;
            r_z1 <= '0;
            r_z2 <= '0;
            o_root_0 <= '0;
            o_root_1 <= '0;
            o_root_2 <= '0;
            o_root_3 <= '0;
        end
        if (r_mphase == 2'd1 && w_mdone) begin
            r_bb   <= w_mp;
            r_pneg <= (w_t != '0) && (r_a[COEF_W-1] != w_t[HALF_W-1]);
        end
        if (i_cmd.op == CMD_DISC_F) begin
            if (r_pneg) begin
                r_d1     <= r_bb + w_p4;
                r_d1_neg <= 1'b0;
            end else begin
                r_d1     <= r_bb - w_p4;
                r_d1_neg <= (r_bb < w_p4);
            end
        end
        if (i_cmd.op == CMD_SQ1) begin
            r_s1 <= '0;
        end else if (w_sdone && i_cmd.inner == CMD2_NONE) begin
            r_s1 <= w_sroot;
        end
        if (w_ddone && i_cmd.op == CMD_DIV1) begin
            r_z1 <= w_dq;
        end
        if (w_ddone && i_cmd.op == CMD_DIV2) begin
            r_z2 <= w_dq;
        end
        if (i_cmd.op == CMD_IN_SEL) begin
            r_z <= i_cmd.second ? r_z2 : r_z1;
        end
        if (w_mdone && r_mphase == 2'd0) begin
            r_zz <= w_mp;
        end
        if (w_sdone && i_cmd.inner != CMD2_NONE) begin
            r_s2 <= w_sroot;
        end
        if (i_cmd.inner == CMD2_IN_FIN) begin
            if (i_cmd.second) begin
                o_root_2 <= sat(w_xp);
                o_root_3 <= sat(w_xm);
            end else begin
                o_root_0 <= sat(w_xp);
                o_root_1 <= sat(w_xm);
            end
        end
    end

    always_comb begin
        o_stat.a_zero    = (r_a == '0);
        o_stat.d1_neg    = r_d1_neg;
        o_stat.d1_zero   = (r_d1 == '0);
        o_stat.d2_neg    = (r_zz < FOUR);
        o_stat.mul_done  = w_mdone && (r_mphase == 2'd0 || r_mphase == 2'd2);
        o_stat.sqrt_done = w_sdone;
        o_stat.div_done  = w_ddone;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqs_ctrl
// Controller: sequences one transaction through the datapath and the handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire                  i_stall,
    input  wire sqs_pkg::t_stat  i_stat,
    output sqs_pkg::t_cmd        o_cmd,
    output logic [1:0]           o_status,
    output logic [3:0]           o_mask
);
    import sqs_pkg::*;

    t_state     r_st, n_st;
    logic       r_second, n_second;
    logic [3:0] r_mask, n_mask;
    logic [1:0] r_status, n_status;
    logic       r_ovalid, n_ovalid;
    logic       r_has_z2, n_has_z2;

    // Next state.
    always_comb begin
        n_st     = r_st;
        n_second = r_second;
        n_mask   = r_mask;
        n_status = r_status;
        n_has_z2 = r_has_z2;
        n_ovalid = r_ovalid;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        unique case (r_st)
            S_IDLE: begin
                if (i_valid && !r_ovalid) begin
                    n_mask   = 4'd0;
                    n_second = 1'b0;
                    n_st     = S_DISC;
                end
            end
            S_DISC: begin
                if (i_stat.a_zero) begin
                    n_status = ST_NOT_SYM;
                    n_st     = S_DONE;
                end else begin
                    n_st = S_DISC_W;
                end
            end
            S_DISC_W:  if (i_stat.mul_done) n_st = S_DISC_F;
            S_DISC_F:  n_st = S_SQ1;
            S_SQ1: begin
                if (i_stat.d1_neg) begin
                    n_status = ST_NO_ROOT;
                    n_st     = S_DONE;
                end else begin
                    n_has_z2 = !i_stat.d1_zero;
                    n_st     = S_SQ1_W;
                end
            end
            S_SQ1_W:   if (i_stat.sqrt_done) n_st = S_DIV1;
            S_DIV1:    n_st = S_DIV1_W;
            S_DIV1_W:  if (i_stat.div_done) n_st = r_has_z2 ? S_DIV2 : S_IN_SEL;
            S_DIV2:    n_st = S_DIV2_W;
            S_DIV2_W:  if (i_stat.div_done) n_st = S_IN_SEL;
            S_IN_SEL:  n_st = S_IN_MUL;
            S_IN_MUL:  n_st = S_IN_MUL_W;
            S_IN_MUL_W: if (i_stat.mul_done) n_st = S_IN_SQ;
            S_IN_SQ: begin
                if (i_stat.d2_neg) begin
                    if (!r_second && r_has_z2) begin
                        n_second = 1'b1;
                        n_st     = S_IN_SEL;
                    end else begin
                        n_st = S_DONE;
                    end
                end else begin
                    n_st = S_IN_SQ_W;
                end
            end
            S_IN_SQ_W: if (i_stat.sqrt_done) n_st = S_IN_FIN;
            S_IN_FIN: begin
                n_mask = r_mask | (r_second ? 4'b1100 : 4'b0011);
                if (!r_second && r_has_z2) begin
                    n_second = 1'b1;
                    n_st     = S_IN_SEL;
                end else begin
                    n_st = S_DONE;
                end
            end
            S_DONE: begin
                if (r_status != ST_NOT_SYM) begin
                    n_status = (r_mask != 4'd0) ? ST_OK : ST_NO_ROOT;
                end
                n_ovalid = 1'b1;
                n_st     = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_IDLE && i_valid && !r_ovalid) begin
            n_status = ST_OK;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.op     = CMD_NONE;
        o_cmd.inner  = CMD2_NONE;
        o_cmd.second = r_second;
        unique case (r_st)
            S_IDLE:   if (i_valid && !r_ovalid) o_cmd.op = CMD_LOAD;
            S_DISC:   if (!i_stat.a_zero) o_cmd.op = CMD_DISC;
            S_DISC_F: o_cmd.op = CMD_DISC_F;
            S_SQ1:    if (!i_stat.d1_neg) o_cmd.op = CMD_SQ1;
            S_DIV1:   o_cmd.op = CMD_DIV1;
            S_DIV1_W: o_cmd.op = CMD_DIV1;
            S_DIV2:   o_cmd.op = CMD_DIV2;
            S_DIV2_W: o_cmd.op = CMD_DIV2;
            S_IN_SEL: o_cmd.op = CMD_IN_SEL;
            S_IN_MUL: o_cmd.inner = CMD2_IN_MUL;
            S_IN_SQ:  if (!i_stat.d2_neg) o_cmd.inner = CMD2_IN_SQ;
            S_IN_SQ_W: o_cmd.inner = CMD2_IN_SQ;
            S_IN_FIN: o_cmd.inner = CMD2_IN_FIN;
            default:  o_cmd.op = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_second <= 1'b0;
            r_mask   <= 4'd0;
            r_status <= ST_OK;
            r_has_z2 <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
            r_second <= n_second;
            r_mask   <= n_mask;
            r_status <= n_status;
            r_has_z2 <= n_has_z2;
        end
    end

    assign o_stall  = (r_st != S_IDLE) || r_ovalid;
    assign o_valid  = r_ovalid;
    assign o_status = r_status;
    assign o_mask   = r_mask;

endmodule

`default_nettype wire

// ===== hw/rtl/symmetric_quartic_solver.sv =====
// ----------------------------------------------------------------------------
// symmetric_quartic_solver
// Real roots of a*x^4 + b*x^3 + c*x^2 + b*x + a = 0 in signed Q16.16.
//
//   channel | handshake                | payload
//   in      | i_valid / o_stall        | i_coef_a, i_coef_b, i_coef_c
//   out     | o_valid / i_stall        | o_status, o_root_valid_mask, o_root_0..3
//
// One transaction at a time. When a is zero the run ends after the check of a;
// otherwise its length is set by the bisection square roots (each halving is a
// test and then the four partial products, at most 48 halvings per root) and
// up to two divisions. The result holds until taken; the next transaction is
// accepted once the result has left. Synchronous active-low reset, no clearing
// pass.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetric_quartic_solver #(
    parameter int FRAC_BITS  = sqs_pkg::FRAC_BITS_DEF,
    parameter int SQRT_STEPS = sqs_pkg::SQRT_STEPS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire signed [sqs_pkg::COEF_W-1:0]  i_coef_a,
    input  wire signed [sqs_pkg::COEF_W-1:0]  i_coef_b,
    input  wire signed [sqs_pkg::COEF_W-1:0]  i_coef_c,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic [1:0]                        o_status,
    output logic [3:0]                        o_root_valid_mask,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_0,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_1,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_2,
    output logic signed [sqs_pkg::ROOT_W-1:0] o_root_3
);
    import sqs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    sqs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_status (o_status),
        .o_mask   (o_root_valid_mask)
    );

    sqs_datapath #(.FRAC_BITS(FRAC_BITS), .SQRT_STEPS(SQRT_STEPS)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .o_stat   (w_stat),
        .o_root_0 (o_root_0),
        .o_root_1 (o_root_1),
        .o_root_2 (o_root_2),
        .o_root_3 (o_root_3)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sqs_checker.sv =====
// ----------------------------------------------------------------------------
// sqs_checker
// Port-level checks on the solver's handshake and result coding.
// ----------------------------------------------------------------------------
`default_nettype none

module sqs_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [1:0]  o_status,
    input wire [3:0]  o_root_valid_mask
);
    // Hold a stalled result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("stalled result changed");

    // Ok status comes with at least one root.
    a_ok_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == 2'd0 |-> o_root_valid_mask != 4'd0)
        else $error("ok without roots");

    // Error status carries no roots.
    a_err_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> o_root_valid_mask == 4'd0)
        else $error("roots with error status");

    // No new transaction is taken while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

endmodule

bind symmetric_quartic_solver sqs_checker u_sqs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_status          (o_status),
    .o_root_valid_mask (o_root_valid_mask)
);

`default_nettype wire
